/* sv/pbrd_pkg.sv */
`default_nettype none

package pbrd_pkg;

  // Sample width of the pulse sensor ADC.
  localparam int SAMPLE_BITS = 10;

  // Widths fixed by the register map and the result word.
  localparam int START_W    = 10;
  localparam int VAL_W      = (SAMPLE_BITS > START_W) ? SAMPLE_BITS : START_W;
  localparam int BAND_W     = SAMPLE_BITS - 2;
  localparam int WIN_W      = 8;
  localparam int PER_W      = 16;
  localparam int SCALE_W    = 8;
  localparam int BEAT_W     = 8;
  localparam int SUM_W      = 16;
  localparam int IVL_W      = 8;
  localparam int RATE_W     = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int DIV_CNT_W  = $clog2(SUM_W);

  // Register reset values.
  localparam logic [WIN_W-1:0]   WINDOW_LENGTH_RST  = WIN_W'(40);
  localparam logic [PER_W-1:0]   REPORT_PERIOD_RST  = PER_W'(200);
  localparam logic [SCALE_W-1:0] RATE_SCALE_RST     = SCALE_W'(12);
  localparam logic [START_W-1:0] MINIMUM_START_RST  = START_W'(900);
  localparam logic [START_W-1:0] MIDPOINT_START_RST = START_W'(550);

  localparam logic [IVL_W-1:0]  IVL_MAX  = '1;
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH  = 3'd0,
    CFG_REPORT_PERIOD  = 3'd1,
    CFG_RATE_SCALE     = 3'd2,
    CFG_MINIMUM_START  = 3'd3,
    CFG_MIDPOINT_START = 3'd4
  } cfg_idx_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_STAT   = 6'b000010,
    ST_DETECT = 6'b000100,
    ST_ACCUM  = 6'b001000,
    ST_DIVIDE = 6'b010000,
    ST_OUT    = 6'b100000
  } state_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [IVL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

/* sv/pulse_beat_rate_detector.sv */
`default_nettype none

// Channel   Direction  Handshake            Word
// in_       input      in_valid / in_stall  in_sample
// out_      output     out_valid/out_stall  out_beat_rate, out_above_band,
//                                           out_beat_event, out_rate_updated
// cfg_      input      cfg_we               cfg_index, cfg_wdata
//
// A sample passes through acceptance, window statistics, beat detection and
// accumulation before its word is offered; when it ends a report interval,
// the bit-serial divider that forms the average also runs before the offer.
// One sample is worked on at a time: in_stall is high from acceptance until
// the result word has been taken, so a stalled output holds off the input.
// Reset is synchronous and active low; it loads all register defaults and
// clears the detector state.

module pulse_beat_rate_detector (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [pbrd_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [pbrd_pkg::RATE_W-1:0]           out_beat_rate,
  output logic                                  out_above_band,
  output logic                                  out_beat_event,
  output logic                                  out_rate_updated,
  input  wire logic                             cfg_we,
  input  wire logic [pbrd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pbrd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // Configuration registers.
  logic [pbrd_pkg::WIN_W-1:0]   win_len_r;
  logic [pbrd_pkg::PER_W-1:0]   period_r;
  logic [pbrd_pkg::SCALE_W-1:0] scale_r;
  logic [pbrd_pkg::START_W-1:0] min_start_r;
  logic [pbrd_pkg::START_W-1:0] mid_start_r;

  // Sequencer and the sample being worked on.
  pbrd_pkg::state_t                 state_r, state_nxt;
  logic [pbrd_pkg::SAMPLE_BITS-1:0] sample_r;

  // Detector state.
  logic [pbrd_pkg::SAMPLE_BITS-1:0] max_r, max_nxt;
  logic [pbrd_pkg::SAMPLE_BITS-1:0] min_r, min_nxt;
  logic [pbrd_pkg::WIN_W-1:0]       win_cnt_r, win_cnt_nxt;
  logic [pbrd_pkg::SAMPLE_BITS-1:0] mid_r, mid_nxt;
  logic [pbrd_pkg::BAND_W-1:0]      band_r, band_nxt;
  logic                             thr_set_r, thr_set_nxt;
  logic                             armed_r, armed_nxt;
  logic [pbrd_pkg::BEAT_W-1:0]      beat_cnt_r, beat_cnt_nxt;
  logic [pbrd_pkg::PER_W-1:0]       tick_cnt_r, tick_cnt_nxt;
  logic [pbrd_pkg::SUM_W-1:0]       sum_r, sum_nxt;
  logic [pbrd_pkg::IVL_W-1:0]       ivl_r, ivl_nxt;
  logic [pbrd_pkg::RATE_W-1:0]      rate_r, rate_nxt;

  // Per-sample flags that travel to the result word.
  logic tick_end_r, tick_end_nxt;
  logic above_r, above_nxt;
  logic beat_r, beat_nxt;

  // Window statistics terms.
  logic [pbrd_pkg::SAMPLE_BITS-1:0] new_max, new_min, min_lim, swing;
  logic [pbrd_pkg::WIN_W-1:0]       win_inc;
  logic [pbrd_pkg::PER_W-1:0]       tick_inc;

  // Beat detection terms.
  logic [pbrd_pkg::VAL_W-1:0] mid_sel, lo;
  logic [pbrd_pkg::VAL_W:0]   hi, s_ext;
  logic                       beat_now, armed_mid;

  // Accumulation terms.
  logic [pbrd_pkg::SUM_W-1:0] prod, sum_add;

  pbrd_pkg::div_req_t div_req;
  pbrd_pkg::div_rsp_t div_rsp;

  pbrd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration writes; indexes past the register list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r   <= pbrd_pkg::WINDOW_LENGTH_RST;
      period_r    <= pbrd_pkg::REPORT_PERIOD_RST;
      scale_r     <= pbrd_pkg::RATE_SCALE_RST;
      min_start_r <= pbrd_pkg::MINIMUM_START_RST;
      mid_start_r <= pbrd_pkg::MIDPOINT_START_RST;
    end else if (cfg_we) begin
      case (pbrd_pkg::cfg_idx_t'(cfg_index))
        pbrd_pkg::CFG_WINDOW_LENGTH:  win_len_r   <= cfg_wdata[pbrd_pkg::WIN_W-1:0];
        pbrd_pkg::CFG_REPORT_PERIOD:  period_r    <= cfg_wdata[pbrd_pkg::PER_W-1:0];
        pbrd_pkg::CFG_RATE_SCALE:     scale_r     <= cfg_wdata[pbrd_pkg::SCALE_W-1:0];
        pbrd_pkg::CFG_MINIMUM_START:  min_start_r <= cfg_wdata[pbrd_pkg::START_W-1:0];
        pbrd_pkg::CFG_MIDPOINT_START: mid_start_r <= cfg_wdata[pbrd_pkg::START_W-1:0];
        default: ;
      endcase
    end
  end

  // Window statistics. The running minimum starts at all ones, so limiting
  // it to minimum_start at the window end gives the same result as a minimum
  // loaded with minimum_start, and a new start value takes effect at once.
  always_comb begin
    new_max  = (sample_r > max_r) ? sample_r : max_r;
    new_min  = (sample_r < min_r) ? sample_r : min_r;
    win_inc  = win_cnt_r + 1'b1;
    tick_inc = tick_cnt_r + 1'b1;
    if (pbrd_pkg::VAL_W'(new_min) < pbrd_pkg::VAL_W'(min_start_r)) begin
      min_lim = new_min;
    end else begin
      min_lim = pbrd_pkg::SAMPLE_BITS'(min_start_r);
    end
    swing = (new_max >= min_lim) ? (new_max - min_lim) : '0;
  end

  // Beat detection against the current thresholds. Before the first window
  // has ended, midpoint_start stands in for the midpoint.
  always_comb begin
    mid_sel   = thr_set_r ? pbrd_pkg::VAL_W'(mid_r) : pbrd_pkg::VAL_W'(mid_start_r);
    hi        = {1'b0, mid_sel} + (pbrd_pkg::VAL_W + 1)'(band_r);
    s_ext     = (pbrd_pkg::VAL_W + 1)'(sample_r);
    lo        = mid_sel - pbrd_pkg::VAL_W'(band_r);
    beat_now  = (s_ext > hi) && !armed_r;
    armed_mid = armed_r || beat_now;
  end

  // The scaled beat count of the closing interval joins the running sum.
  always_comb begin
    prod    = pbrd_pkg::SUM_W'(beat_cnt_r) * pbrd_pkg::SUM_W'(scale_r);
    sum_add = sum_r + prod;
  end

  assign div_req.start    = (state_r == pbrd_pkg::ST_ACCUM) && tick_end_r;
  assign div_req.dividend = sum_add;
  assign div_req.divisor  = ivl_r;

  always_comb begin
    state_nxt    = state_r;
    max_nxt      = max_r;
    min_nxt      = min_r;
    win_cnt_nxt  = win_cnt_r;
    mid_nxt      = mid_r;
    band_nxt     = band_r;
    thr_set_nxt  = thr_set_r;
    armed_nxt    = armed_r;
    beat_cnt_nxt = beat_cnt_r;
    tick_cnt_nxt = tick_cnt_r;
    sum_nxt      = sum_r;
    ivl_nxt      = ivl_r;
    rate_nxt     = rate_r;
    tick_end_nxt = tick_end_r;
    above_nxt    = above_r;
    beat_nxt     = beat_r;
    case (state_r)
      pbrd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = pbrd_pkg::ST_STAT;
        end
      end
      pbrd_pkg::ST_STAT: begin
        // A window length of zero lets the count wrap, giving 256 samples.
        if (win_inc == win_len_r) begin
          mid_nxt     = new_max - (swing >> 1);
          band_nxt    = swing[pbrd_pkg::SAMPLE_BITS-1:2];
          thr_set_nxt = 1'b1;
          win_cnt_nxt = '0;
          max_nxt     = '0;
          min_nxt     = '1;
        end else begin
          win_cnt_nxt = win_inc;
          max_nxt     = new_max;
          min_nxt     = new_min;
        end
        tick_end_nxt = (tick_inc == period_r);
        tick_cnt_nxt = (tick_inc == period_r) ? '0 : tick_inc;
        state_nxt    = pbrd_pkg::ST_DETECT;
      end
      pbrd_pkg::ST_DETECT: begin
        beat_nxt  = beat_now;
        above_nxt = (s_ext >= hi);
        if (beat_now) begin
          beat_cnt_nxt = beat_cnt_r + 1'b1;
        end
        // Re-arm only when the lower threshold lies at or above zero.
        if (armed_mid && (mid_sel >= pbrd_pkg::VAL_W'(band_r)) &&
            (pbrd_pkg::VAL_W'(sample_r) < lo)) begin
          armed_nxt = 1'b0;
        end else begin
          armed_nxt = armed_mid;
        end
        state_nxt = pbrd_pkg::ST_ACCUM;
      end
      pbrd_pkg::ST_ACCUM: begin
        if (tick_end_r) begin
          sum_nxt      = sum_add;
          beat_cnt_nxt = '0;
          // The divider has latched the old interval count already.
          if (ivl_r != pbrd_pkg::IVL_MAX) begin
            ivl_nxt = ivl_r + 1'b1;
          end
          state_nxt = pbrd_pkg::ST_DIVIDE;
        end else begin
          state_nxt = pbrd_pkg::ST_OUT;
        end
      end
      pbrd_pkg::ST_DIVIDE: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient > pbrd_pkg::SUM_W'(pbrd_pkg::RATE_MAX)) begin
            rate_nxt = pbrd_pkg::RATE_MAX;
          end else begin
            rate_nxt = div_rsp.quotient[pbrd_pkg::RATE_W-1:0];
          end
          state_nxt = pbrd_pkg::ST_OUT;
        end
      end
      pbrd_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_nxt = pbrd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pbrd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pbrd_pkg::ST_IDLE;
      max_r      <= '0;
      min_r      <= '1;
      win_cnt_r  <= '0;
      mid_r      <= '0;
      band_r     <= '0;
      thr_set_r  <= 1'b0;
      armed_r    <= 1'b0;
      beat_cnt_r <= '0;
      tick_cnt_r <= '0;
      sum_r      <= '0;
      ivl_r      <= pbrd_pkg::IVL_W'(1);
      rate_r     <= '0;
      tick_end_r <= 1'b0;
      above_r    <= 1'b0;
      beat_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      max_r      <= max_nxt;
      min_r      <= min_nxt;
      win_cnt_r  <= win_cnt_nxt;
      mid_r      <= mid_nxt;
      band_r     <= band_nxt;
      thr_set_r  <= thr_set_nxt;
      armed_r    <= armed_nxt;
      beat_cnt_r <= beat_cnt_nxt;
      tick_cnt_r <= tick_cnt_nxt;
      sum_r      <= sum_nxt;
      ivl_r      <= ivl_nxt;
      rate_r     <= rate_nxt;
      tick_end_r <= tick_end_nxt;
      above_r    <= above_nxt;
      beat_r     <= beat_nxt;
    end
  end

  // The sample is captured on acceptance and held until the word is taken.
  always_ff @(posedge clk) begin
    if ((state_r == pbrd_pkg::ST_IDLE) && in_valid) begin
      sample_r <= in_sample;
    end
  end

  assign in_stall         = (state_r != pbrd_pkg::ST_IDLE);
  assign out_valid        = (state_r == pbrd_pkg::ST_OUT);
  assign out_beat_rate    = rate_r;
  assign out_above_band   = above_r;
  assign out_beat_event   = beat_r;
  assign out_rate_updated = tick_end_r;

endmodule

`default_nettype wire

/* sv/pbrd_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module pbrd_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pbrd_pkg::div_req_t req,
  output pbrd_pkg::div_rsp_t      rsp
);

  logic [pbrd_pkg::IVL_W-1:0]     rem_r, rem_nxt;
  logic [pbrd_pkg::SUM_W-1:0]     quo_r, quo_nxt;
  logic [pbrd_pkg::IVL_W-1:0]     dvs_r, dvs_nxt;
  logic [pbrd_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;

  logic [pbrd_pkg::IVL_W:0] shifted;
  logic [pbrd_pkg::IVL_W:0] diff;
  logic                     ge;

  always_comb begin
    shifted  = {rem_r, quo_r[pbrd_pkg::SUM_W-1]};
    diff     = shifted - {1'b0, dvs_r};
    ge       = (shifted >= {1'b0, dvs_r});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // A partial remainder that fails the trial stays below the divisor.
      rem_nxt = ge ? diff[pbrd_pkg::IVL_W-1:0] : shifted[pbrd_pkg::IVL_W-1:0];
      quo_nxt = {quo_r[pbrd_pkg::SUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == pbrd_pkg::DIV_CNT_W'(pbrd_pkg::SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

/* sv/pbrd_checker.sv */
`default_nettype none

module pbrd_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [pbrd_pkg::RATE_W-1:0] out_beat_rate,
  input wire logic                        out_above_band,
  input wire logic                        out_beat_event,
  input wire logic                        out_rate_updated
);

  // Reset leaves no word on offer.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // No new sample is taken while a word is still waiting.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while a result is pending");

  // Right after an accepted sample, the input is stalled and no word is on offer.
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (in_stall && !out_valid))
    else $error("result or new acceptance right after a sample");

  // A counted beat means the sample cleared the upper threshold.
  a_beat_above: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat_event) |-> out_above_band)
    else $error("beat reported below the upper threshold");

  // A stalled word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_beat_rate) &&
      $stable(out_above_band) && $stable(out_beat_event) && $stable(out_rate_updated)))
    else $error("stalled result changed");

endmodule

bind pulse_beat_rate_detector pbrd_checker u_pbrd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_beat_rate    (out_beat_rate),
  .out_above_band   (out_above_band),
  .out_beat_event   (out_beat_event),
  .out_rate_updated (out_rate_updated)
);

`default_nettype wire

/* tb/sv/pulse_beat_rate_detector_tb.sv */
module pulse_beat_rate_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One result word as the block reports it for a single sample.
  typedef struct packed {
    logic [pbrd_pkg::RATE_W-1:0] rate;
    logic                        above;
    logic                        beat;
    logic                        upd;
  } beat_word_t;

  // A row of the directed table either writes a register or sends a sample.
  // Rows whose expected word is obvious carry it typed in; the others are
  // checked against the predictor.
  typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                       kind;
    pbrd_pkg::cfg_idx_t              idx;
    logic [pbrd_pkg::CFG_DATA_W-1:0] value;
    bit                              typed;
    beat_word_t                      want;
  } dir_row_t;

  // One random phase: register settings (a negative value means pick one at
  // random), how many samples to send and the longest half period of the
  // synthetic pulse wave.
  typedef struct {
    int win;
    int per;
    int scale;
    int min_st;
    int mid_st;
    int items;
    int half_max;
  } plan_t;

  localparam beat_word_t QUIET    = '{8'd0, 1'b0, 1'b0, 1'b0};
  localparam beat_word_t ABOVE    = '{8'd0, 1'b1, 1'b0, 1'b0};
  localparam beat_word_t NEW_BEAT = '{8'd0, 1'b1, 1'b1, 1'b0};

  // Right after reset the midpoint is midpoint_start (550) and the band is
  // zero, so the first rows can be read off directly: a beat needs a sample
  // strictly above the midpoint, re-arming needs one strictly below it.
  dir_row_t directed_rows [30] = '{
    '{ROW_SAMPLE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd0, 1'b1, QUIET},
    '{ROW_SAMPLE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd1023, 1'b1, NEW_BEAT},
    '{ROW_SAMPLE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd551, 1'b1, ABOVE},
    '{ROW_SAMPLE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd550, 1'b1, ABOVE},
    '{ROW_SAMPLE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd549, 1'b1, QUIET},
    '{ROW_SAMPLE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd551, 1'b1, NEW_BEAT},
    // The start midpoint applies at once while no window has ended.
    '{ROW_WRITE, pbrd_pkg::CFG_MIDPOINT_START, 16'd1023, 1'b0, QUIET},
    '{ROW_SAMPLE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd1023, 1'b1, ABOVE},
    '{ROW_SAMPLE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd0, 1'b1, QUIET},
    '{ROW_SAMPLE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd1023, 1'b1, ABOVE},
    // With a zero midpoint the re-arm threshold is never undercut.
    '{ROW_WRITE, pbrd_pkg::CFG_MIDPOINT_START, 16'd0, 1'b0, QUIET},
    '{ROW_SAMPLE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd0, 1'b1, ABOVE},
    '{ROW_SAMPLE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd1, 1'b1, NEW_BEAT},
    '{ROW_WRITE, pbrd_pkg::CFG_MIDPOINT_START, 16'd550, 1'b0, QUIET},
    // Short windows and intervals with the largest scale and a zero
    // minimum start, so thresholds move and the rate saturates.
    '{ROW_WRITE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd3, 1'b0, QUIET},
    '{ROW_WRITE, pbrd_pkg::CFG_REPORT_PERIOD, 16'd5, 1'b0, QUIET},
    '{ROW_WRITE, pbrd_pkg::CFG_RATE_SCALE, 16'd255, 1'b0, QUIET},
    '{ROW_WRITE, pbrd_pkg::CFG_MINIMUM_START, 16'd0, 1'b0, QUIET},
    '{ROW_SAMPLE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd1023, 1'b0, QUIET},
    '{ROW_SAMPLE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd0, 1'b0, QUIET},
    '{ROW_SAMPLE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd1023, 1'b0, QUIET},
    '{ROW_SAMPLE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd0, 1'b0, QUIET},
    '{ROW_SAMPLE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd512, 1'b0, QUIET},
    '{ROW_SAMPLE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd1023, 1'b0, QUIET},
    '{ROW_SAMPLE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd0, 1'b0, QUIET},
    '{ROW_WRITE, pbrd_pkg::CFG_MINIMUM_START, 16'd1023, 1'b0, QUIET},
    '{ROW_SAMPLE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd700, 1'b0, QUIET},
    '{ROW_SAMPLE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd300, 1'b0, QUIET},
    '{ROW_SAMPLE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd1023, 1'b0, QUIET},
    '{ROW_SAMPLE, pbrd_pkg::CFG_WINDOW_LENGTH, 16'd0, 1'b0, QUIET}
  };

  // The first phase saturates the rate and wraps the rate sum, the second
  // drives the interval count into saturation, the third packs more than
  // 255 beats into one interval, the fourth uses zero window and period
  // (wrap-around lengths), the fifth the largest window and period, and the last
  // draws its settings at random.
  plan_t plans [6] = '{
    '{2, 4, 255, 0, 550, 600, 1},
    '{1, 1, 1, 1023, 1023, 150, 6},
    '{2, 700, 3, 0, 0, 720, 1},
    '{0, 0, 12, 900, 1023, 260, 20},
    '{255, 65535, 128, 512, 0, 60, 10},
    '{-1, -1, -1, -1, -1, 60, 12}
  };

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [pbrd_pkg::SAMPLE_BITS-1:0] in_sample = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [pbrd_pkg::RATE_W-1:0]      out_beat_rate;
  logic                             out_above_band;
  logic                             out_beat_event;
  logic                             out_rate_updated;
  logic                             cfg_we = 1'b0;
  pbrd_pkg::cfg_idx_t               cfg_index = pbrd_pkg::CFG_WINDOW_LENGTH;
  logic [pbrd_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Words predicted for accepted samples, oldest first.
  beat_word_t beat_words_due [$];
  int         errors = 0;
  int         words_seen = 0;
  int         hold_left = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  // Predictor copy of the register file.
  logic [pbrd_pkg::WIN_W-1:0]   len_reg = pbrd_pkg::WINDOW_LENGTH_RST;
  logic [pbrd_pkg::PER_W-1:0]   period_reg = pbrd_pkg::REPORT_PERIOD_RST;
  logic [pbrd_pkg::SCALE_W-1:0] scale_reg = pbrd_pkg::RATE_SCALE_RST;
  logic [pbrd_pkg::START_W-1:0] min_start_reg = pbrd_pkg::MINIMUM_START_RST;
  logic [pbrd_pkg::START_W-1:0] mid_start_reg = pbrd_pkg::MIDPOINT_START_RST;

  // Predictor copy of the detector state.
  logic [pbrd_pkg::SAMPLE_BITS-1:0] win_max = '0;
  logic [pbrd_pkg::SAMPLE_BITS-1:0] win_min = '1;
  logic [pbrd_pkg::WIN_W-1:0]       win_cnt = '0;
  logic [pbrd_pkg::SAMPLE_BITS-1:0] mid_lvl = '0;
  logic [pbrd_pkg::BAND_W-1:0]      band_lvl = '0;
  bit                               thr_valid = 1'b0;
  bit                               armed = 1'b0;
  logic [pbrd_pkg::BEAT_W-1:0]      beats = '0;
  logic [pbrd_pkg::PER_W-1:0]       ticks = '0;
  logic [pbrd_pkg::SUM_W-1:0]       sum_acc = '0;
  logic [pbrd_pkg::IVL_W-1:0]       periods = pbrd_pkg::IVL_W'(1);
  logic [pbrd_pkg::RATE_W-1:0]      rate_now = '0;

  // Synthetic pulse wave: a square wave with noise, occasionally replaced
  // by uniform noise or rail-to-rail values to break the pattern.
  int seq_left = 0;
  int seq_mode = 0;
  int wave_base = 0;
  int wave_amp = 0;
  int wave_half = 1;
  int wave_noise = 0;
  int wave_pos = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pulse_beat_rate_detector u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_beat_rate    (out_beat_rate),
    .out_above_band   (out_above_band),
    .out_beat_event   (out_beat_event),
    .out_rate_updated (out_rate_updated),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // Advances the predictor by one sample and returns the word it causes.
  // Window statistics are updated first, so the thresholds that decide the
  // beat already include this sample's window end.
  task automatic predict_beat_word(input logic [pbrd_pkg::SAMPLE_BITS-1:0] s,
                                   output beat_word_t w);
    int mn;
    int swing;
    int mid;
    int hi;
    int band;
    int quot;
    w = '0;
    if (s > win_max) win_max = s;
    if (s < win_min) win_min = s;
    win_cnt++;
    ticks++;
    if (win_cnt == len_reg) begin
      // The window minimum never exceeds the configured start value.
      mn = (win_min < min_start_reg) ? int'(win_min) : int'(min_start_reg);
      swing = (int'(win_max) >= mn) ? int'(win_max) - mn : 0;
      mid_lvl = pbrd_pkg::SAMPLE_BITS'(int'(win_max) - swing / 2);
      band_lvl = pbrd_pkg::BAND_W'(swing / 4);
      thr_valid = 1'b1;
      win_cnt = '0;
      win_max = '0;
      win_min = '1;
    end
    mid = thr_valid ? int'(mid_lvl) : int'(mid_start_reg);
    band = int'(band_lvl);
    hi = mid + band;
    if (int'(s) > hi && !armed) begin
      beats++;
      armed = 1'b1;
      w.beat = 1'b1;
    end
    // A negative re-arm threshold can never be undercut.
    if (armed && mid >= band && int'(s) < mid - band) armed = 1'b0;
    if (ticks == period_reg) begin
      sum_acc = pbrd_pkg::SUM_W'(int'(sum_acc) + int'(beats) * int'(scale_reg));
      quot = int'(sum_acc) / int'(periods);
      rate_now = (quot > 255) ? pbrd_pkg::RATE_MAX : pbrd_pkg::RATE_W'(quot);
      ticks = '0;
      beats = '0;
      if (periods != pbrd_pkg::IVL_MAX) periods++;
      w.upd = 1'b1;
    end
    w.above = (int'(s) >= hi);
    w.rate = rate_now;
  endtask

  // Offers one sample, possibly after a random gap, and records the word
  // it is expected to cause once the block has taken it.
  task automatic send_sample(input logic [pbrd_pkg::SAMPLE_BITS-1:0] s, input bit typed,
                             input beat_word_t typed_word);
    beat_word_t w;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat_word(s, w);
    beat_words_due.push_back(typed ? typed_word : w);
  endtask

  // Stops offering samples and waits until every predicted word is back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (beat_words_due.size() != 0);
  endtask

  task automatic write_reg(input pbrd_pkg::cfg_idx_t idx,
                           input logic [pbrd_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      pbrd_pkg::CFG_WINDOW_LENGTH:  len_reg = val[pbrd_pkg::WIN_W-1:0];
      pbrd_pkg::CFG_REPORT_PERIOD:  period_reg = val[pbrd_pkg::PER_W-1:0];
      pbrd_pkg::CFG_RATE_SCALE:     scale_reg = val[pbrd_pkg::SCALE_W-1:0];
      pbrd_pkg::CFG_MINIMUM_START:  min_start_reg = val[pbrd_pkg::START_W-1:0];
      pbrd_pkg::CFG_MIDPOINT_START: mid_start_reg = val[pbrd_pkg::START_W-1:0];
      default: ;
    endcase
  endtask

  // Writes a register with the block idle. Window and interval counters only
  // restart on an exact match, so lowering a length to or below the running
  // count would stall progress for a full counter wrap. In that case the length
  // is first set to end the current window or interval on the next sample.
  task automatic set_register(input pbrd_pkg::cfg_idx_t idx, input int val);
    drain();
    if (idx == pbrd_pkg::CFG_WINDOW_LENGTH && val != 0 && int'(win_cnt) >= val) begin
      write_reg(idx, pbrd_pkg::CFG_DATA_W'((int'(win_cnt) + 1) % 256));
      send_sample(pbrd_pkg::SAMPLE_BITS'($urandom_range(0, 1023)), 1'b0, QUIET);
      drain();
    end
    if (idx == pbrd_pkg::CFG_REPORT_PERIOD && val != 0 && int'(ticks) >= val) begin
      write_reg(idx, pbrd_pkg::CFG_DATA_W'((int'(ticks) + 1) % 65536));
      send_sample(pbrd_pkg::SAMPLE_BITS'($urandom_range(0, 1023)), 1'b0, QUIET);
      drain();
    end
    write_reg(idx, pbrd_pkg::CFG_DATA_W'(val));
  endtask

  task automatic next_pulse(input int half_max,
                            output logic [pbrd_pkg::SAMPLE_BITS-1:0] s);
    int v;
    if (seq_left == 0) begin
      seq_left = $urandom_range(8, 48);
      seq_mode = $urandom_range(0, 99);
      wave_base = $urandom_range(0, 200);
      wave_amp = $urandom_range(300, 823);
      wave_half = $urandom_range(1, half_max);
      wave_noise = $urandom_range(0, 20);
      wave_pos = 0;
    end
    seq_left--;
    if (seq_mode < 85) begin
      v = (wave_pos < wave_half) ? wave_base + wave_amp : wave_base;
      v = v + int'($urandom_range(0, 2 * wave_noise)) - wave_noise;
      wave_pos = (wave_pos + 1) % (2 * wave_half);
    end else if (seq_mode < 95) begin
      v = $urandom_range(0, 1023);
    end else begin
      v = ($urandom_range(0, 1) != 0) ? 1023 : 0;
    end
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    s = pbrd_pkg::SAMPLE_BITS'(v);
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    errors++;
    $display("word %0d: %s is %0d, expected %0d", words_seen, what, got, want);
  endtask

  // Result side: every taken word is compared field by field with the
  // oldest prediction. The stall is redrawn each cycle, except during the
  // two long hold-offs, which let the block fill and stall its input.
  always @(posedge clk) begin : result_side
    beat_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (beat_words_due.size() == 0) begin
          flag_mismatch("unexpected word, rate", out_beat_rate, -1);
        end else begin
          want = beat_words_due.pop_front();
          if (out_beat_rate !== want.rate)
            flag_mismatch("beat_rate", out_beat_rate, want.rate);
          if (out_above_band !== want.above)
            flag_mismatch("above_band", out_above_band, want.above);
          if (out_beat_event !== want.beat)
            flag_mismatch("beat_event", out_beat_event, want.beat);
          if (out_rate_updated !== want.upd)
            flag_mismatch("rate_updated", out_rate_updated, want.upd);
        end
        words_seen++;
        if (words_seen == 500 || words_seen == 1400) hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int                               sent;
    int                               val;
    logic [pbrd_pkg::SAMPLE_BITS-1:0] s;
    sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 19;
    recv_idle_pct = 68;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE)
        set_register(directed_rows[i].idx, int'(directed_rows[i].value));
      else
        send_sample(directed_rows[i].value[pbrd_pkg::SAMPLE_BITS-1:0],
                    directed_rows[i].typed, directed_rows[i].want);
    end

    foreach (plans[p]) begin
      val = (plans[p].win < 0) ? int'($urandom_range(3, 40)) : plans[p].win;
      set_register(pbrd_pkg::CFG_WINDOW_LENGTH, val);
      val = (plans[p].per < 0) ? int'($urandom_range(20, 120)) : plans[p].per;
      set_register(pbrd_pkg::CFG_REPORT_PERIOD, val);
      val = (plans[p].scale < 0) ? int'($urandom_range(0, 255)) : plans[p].scale;
      set_register(pbrd_pkg::CFG_RATE_SCALE, val);
      val = (plans[p].min_st < 0) ? int'($urandom_range(0, 1023)) : plans[p].min_st;
      set_register(pbrd_pkg::CFG_MINIMUM_START, val);
      val = (plans[p].mid_st < 0) ? int'($urandom_range(0, 1023)) : plans[p].mid_st;
      set_register(pbrd_pkg::CFG_MIDPOINT_START, val);
      repeat (plans[p].items) begin
        // Idle pattern: slow receiver first, then slow sender, then full rate.
        if (sent < 600) begin
          send_idle_pct = 19;
          recv_idle_pct = 68;
        end else if (sent < 1200) begin
          send_idle_pct = 68;
          recv_idle_pct = 19;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        next_pulse(plans[p].half_max, s);
        send_sample(s, 1'b0, QUIET);
        sent++;
      end
    end

    drain();
    // Allow a late stray word to show up before deciding.
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
